[rtl/mspfr_pkg.sv]
`timescale 1ns / 1ps

package mspfr_pkg;

    localparam int unsigned MAX_PAYLOAD = 256;
    localparam int unsigned BURST_DEPTH = 9;
    localparam int unsigned CAP_WIDTH = 17;

    localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 17'd65544;
    localparam logic [CAP_WIDTH-1:0] OVERHEAD_V1 = 17'd6;
    localparam logic [CAP_WIDTH-1:0] OVERHEAD_V2 = 17'd9;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic VERSION_1 = 1'b0;
    localparam logic VERSION_2 = 1'b1;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_ERROR = 8'h21;
    localparam logic [7:0] CHAR_REPLY = 8'h3E;
    localparam logic [7:0] FLAGS_BYTE = 8'h00;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    typedef struct packed {
        logic       open;
        logic       version;
        logic [8:0] remaining;
        logic [7:0] checksum;
    } frame_state_t;

    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] data;
        logic [BURST_DEPTH-1:0]      last;
        logic [3:0]                  count;
    } burst_t;

    // CRC-8 DVB-S2 of a single byte that has already been XORed into the register.
    function automatic logic [7:0] crc8_byte(input logic [7:0] value);
        logic [7:0] crc;
        crc = value;
        for (int k = 0; k < 8; k++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

[rtl/mspfr_encoder.sv]
`timescale 1ns / 1ps

module mspfr_encoder (
    input  logic                                opcode,
    input  logic                                protocol_version,
    input  logic [15:0]                         command_id,
    input  logic                                is_error,
    input  logic [8:0]                          payload_length,
    input  logic [7:0]                          payload_byte,
    input  logic [mspfr_pkg::CAP_WIDTH-1:0]     capacity,
    input  mspfr_pkg::frame_state_t             state,
    output mspfr_pkg::frame_state_t             state_next,
    output mspfr_pkg::burst_t                   burst
);

    logic [7:0]                          dir_char;
    logic [7:0]                          cmd_lo;
    logic [7:0]                          cmd_hi;
    logic [7:0]                          len_lo;
    logic [7:0]                          len_hi;
    logic [mspfr_pkg::CAP_WIDTH-1:0]     frame_size;
    logic                                too_long;
    logic                                too_big;
    logic [7:0]                          crc_flags;
    logic [7:0]                          crc_cmd_lo;
    logic [7:0]                          crc_cmd_hi;
    logic [7:0]                          crc_len_lo;
    logic [7:0]                          crc_len_hi;
    logic [7:0]                          xor_header;
    logic [7:0]                          data_check;

    assign dir_char = is_error ? mspfr_pkg::CHAR_ERROR : mspfr_pkg::CHAR_REPLY;
    assign cmd_lo = command_id[7:0];
    assign cmd_hi = command_id[15:8];
    assign len_lo = payload_length[7:0];
    assign len_hi = {7'd0, payload_length[8]};

    assign frame_size = {8'd0, payload_length}
        + ((protocol_version == mspfr_pkg::VERSION_2) ? mspfr_pkg::OVERHEAD_V2
                                                      : mspfr_pkg::OVERHEAD_V1);
    assign too_long = payload_length > 9'(mspfr_pkg::MAX_PAYLOAD);
    assign too_big = frame_size > capacity;

    assign crc_flags = mspfr_pkg::crc8_byte(mspfr_pkg::FLAGS_BYTE);
    assign crc_cmd_lo = mspfr_pkg::crc8_byte(crc_flags ^ cmd_lo);
    assign crc_cmd_hi = mspfr_pkg::crc8_byte(crc_cmd_lo ^ cmd_hi);
    assign crc_len_lo = mspfr_pkg::crc8_byte(crc_cmd_hi ^ len_lo);
    assign crc_len_hi = mspfr_pkg::crc8_byte(crc_len_lo ^ len_hi);
    assign xor_header = len_lo ^ cmd_lo;

    assign data_check = (state.version == mspfr_pkg::VERSION_2)
        ? mspfr_pkg::crc8_byte(state.checksum ^ payload_byte)
        : (state.checksum ^ payload_byte);

    always_comb begin
        state_next = state;
        burst.data = '0;
        burst.last = '0;
        burst.count = 4'd0;
        if (opcode == mspfr_pkg::OP_START) begin
            state_next.open = 1'b0;
            if (!(too_long || too_big)) begin
                state_next.version = protocol_version;
                burst.data[0] = mspfr_pkg::CHAR_DOLLAR;
                burst.data[2] = dir_char;
                if (protocol_version == mspfr_pkg::VERSION_2) begin
                    burst.data[1] = mspfr_pkg::CHAR_X;
                    burst.data[3] = mspfr_pkg::FLAGS_BYTE;
                    burst.data[4] = cmd_lo;
                    burst.data[5] = cmd_hi;
                    burst.data[6] = len_lo;
                    burst.data[7] = len_hi;
                    burst.data[8] = crc_len_hi;
                    burst.last[8] = 1'b1;
                    state_next.checksum = crc_len_hi;
                    burst.count = (payload_length == 9'd0) ? 4'd9 : 4'd8;
                end else begin
                    burst.data[1] = mspfr_pkg::CHAR_M;
                    burst.data[3] = len_lo;
                    burst.data[4] = cmd_lo;
                    burst.data[5] = xor_header;
                    burst.last[5] = 1'b1;
                    state_next.checksum = xor_header;
                    burst.count = (payload_length == 9'd0) ? 4'd6 : 4'd5;
                end
                if (payload_length != 9'd0) begin
                    state_next.open = 1'b1;
                    state_next.remaining = payload_length;
                end
            end
        end else begin
            if (state.open && (state.remaining != 9'd0)) begin
                burst.data[0] = payload_byte;
                burst.data[1] = data_check;
                burst.last[1] = 1'b1;
                state_next.checksum = data_check;
                state_next.remaining = state.remaining - 9'd1;
                if (state.remaining == 9'd1) begin
                    burst.count = 4'd2;
                    state_next.open = 1'b0;
                end else begin
                    burst.count = 4'd1;
                end
            end else begin
                state_next.open = 1'b0;
            end
        end
    end

endmodule

[rtl/msp_response_framer.sv]
`timescale 1ns / 1ps

// Frames replies of the serial control protocol, versions 1 and 2, one byte per output
// word. A start word produces the 5 (v1) or 8 (v2) byte header, plus the checksum when
// the length is zero; each payload word produces its byte and, after the last one, the
// checksum. The words of one input item are held in a nine-entry burst buffer that drains
// into the output register at one word per cycle while m_ready does not stall it. A new
// item is not taken while the buffer holds more than one word, and an item that produces
// nothing leaves the buffer empty. The next item is taken in the cycle in which the
// previous item's last word moves to the output register.

module msp_response_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [16:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic        s_protocol_version,
    input  logic [15:0] s_command_id,
    input  logic        s_is_error,
    input  logic [8:0]  s_payload_length,
    input  logic [7:0]  s_payload_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_last
);

    logic [mspfr_pkg::CAP_WIDTH-1:0] cap_reg;
    mspfr_pkg::frame_state_t         state_reg;
    mspfr_pkg::frame_state_t         state_next;
    mspfr_pkg::burst_t               burst;
    mspfr_pkg::burst_t               buf_reg;
    mspfr_pkg::burst_t               buf_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [7:0]                      m_byte_reg;
    logic [7:0]                      m_byte_next;
    logic                            m_last_reg;
    logic                            m_last_next;
    logic                            out_load;
    logic                            buf_take;
    logic                            accept;

    mspfr_encoder u_encoder (
        .opcode           (s_opcode),
        .protocol_version (s_protocol_version),
        .command_id       (s_command_id),
        .is_error         (s_is_error),
        .payload_length   (s_payload_length),
        .payload_byte     (s_payload_byte),
        .capacity         (cap_reg),
        .state            (state_reg),
        .state_next       (state_next),
        .burst            (burst)
    );

    assign out_load = !m_valid_reg || m_ready;
    assign buf_take = out_load && (buf_reg.count != 4'd0);
    assign s_ready = (buf_reg.count == 4'd0) || ((buf_reg.count == 4'd1) && out_load);
    assign accept = s_valid && s_ready;

    always_comb begin
        buf_next = buf_reg;
        if (accept) begin
            buf_next = burst;
        end else if (buf_take) begin
            buf_next.data = {8'd0, buf_reg.data[mspfr_pkg::BURST_DEPTH-1:1]};
            buf_next.last = {1'b0, buf_reg.last[mspfr_pkg::BURST_DEPTH-1:1]};
            buf_next.count = buf_reg.count - 4'd1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next = m_byte_reg;
        m_last_next = m_last_reg;
        if (out_load) begin
            m_valid_next = buf_reg.count != 4'd0;
            m_byte_next = buf_reg.data[0];
            m_last_next = buf_reg.last[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= mspfr_pkg::CAPACITY_RESET;
            state_reg <= '0;
            buf_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                cap_reg <= cfg_wdata;
            end
            if (accept) begin
                state_reg <= state_next;
            end
            buf_reg <= buf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_last = m_last_reg;

    a_ready_only_near_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (buf_reg.count <= 4'd1))
        else $error("Input taken while the burst buffer still holds several words.");

    a_buffer_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_reg.count <= 4'(mspfr_pkg::BURST_DEPTH))
        else $error("Burst buffer count exceeds its depth.");

    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.open |-> (state_reg.remaining != 9'd0))
        else $error("An open frame has no payload bytes left.");

endmodule

[test/tb_msp_response_framer.sv]
`timescale 1ns / 1ps

module tb_msp_response_framer;

    typedef struct {
        logic        opcode;
        logic        version;
        logic [15:0] command;
        logic        is_error;
        logic [8:0]  length;
        logic [7:0]  data;
    } framer_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    class reply_frame_tracker;
        logic [16:0]  capacity;
        logic         open_q;
        logic         version_q;
        logic [8:0]   remaining_q;
        logic [7:0]   checksum_q;
        frame_word_t  pending_words[$];
        int           errors;

        function new();
            capacity = mspfr_pkg::CAPACITY_RESET;
            open_q = 1'b0;
            version_q = mspfr_pkg::VERSION_1;
            remaining_q = '0;
            checksum_q = '0;
            errors = 0;
        endfunction

        function logic [7:0] mix(logic [7:0] acc, logic [7:0] value);
            logic [7:0] r;
            r = acc ^ value;
            if (version_q == mspfr_pkg::VERSION_2) begin
                for (int i = 0; i < 8; i++) begin
                    r = r[7] ? ({r[6:0], 1'b0} ^ mspfr_pkg::CRC_POLY) : {r[6:0], 1'b0};
                end
            end
            return r;
        endfunction

        function void push_word(logic [7:0] value, logic last);
            pending_words.push_back({value, last});
        endfunction

        function void take_item(framer_item_t it);
            int total;
            logic [7:0] dir;
            if (it.opcode == mspfr_pkg::OP_START) begin
                total = int'(it.length) +
                        ((it.version == mspfr_pkg::VERSION_2)
                            ? int'(mspfr_pkg::OVERHEAD_V2)
                            : int'(mspfr_pkg::OVERHEAD_V1));
                open_q = 1'b0;
                if (it.length > mspfr_pkg::MAX_PAYLOAD || total > int'(capacity)) begin
                    return;
                end
                dir = it.is_error ? mspfr_pkg::CHAR_ERROR : mspfr_pkg::CHAR_REPLY;
                version_q = it.version;
                checksum_q = '0;
                push_word(mspfr_pkg::CHAR_DOLLAR, 1'b0);
                if (it.version == mspfr_pkg::VERSION_2) begin
                    push_word(mspfr_pkg::CHAR_X, 1'b0);
                    push_word(dir, 1'b0);
                    push_word(mspfr_pkg::FLAGS_BYTE, 1'b0);
                    push_word(it.command[7:0], 1'b0);
                    push_word(it.command[15:8], 1'b0);
                    push_word(it.length[7:0], 1'b0);
                    push_word({7'b0, it.length[8]}, 1'b0);
                    checksum_q = mix(checksum_q, mspfr_pkg::FLAGS_BYTE);
                    checksum_q = mix(checksum_q, it.command[7:0]);
                    checksum_q = mix(checksum_q, it.command[15:8]);
                    checksum_q = mix(checksum_q, it.length[7:0]);
                    checksum_q = mix(checksum_q, {7'b0, it.length[8]});
                end else begin
                    push_word(mspfr_pkg::CHAR_M, 1'b0);
                    push_word(dir, 1'b0);
                    push_word(it.length[7:0], 1'b0);
                    push_word(it.command[7:0], 1'b0);
                    checksum_q = mix(checksum_q, it.length[7:0]);
                    checksum_q = mix(checksum_q, it.command[7:0]);
                end
                if (it.length == 0) begin
                    push_word(checksum_q, 1'b1);
                end else begin
                    remaining_q = it.length;
                    open_q = 1'b1;
                end
            end else begin
                if (!open_q || remaining_q == 0) begin
                    open_q = 1'b0;
                    return;
                end
                push_word(it.data, 1'b0);
                checksum_q = mix(checksum_q, it.data);
                remaining_q = remaining_q - 1'b1;
                if (remaining_q == 0) begin
                    push_word(checksum_q, 1'b1);
                    open_q = 1'b0;
                end
            end
        endfunction

        function void match_word(logic [7:0] value, logic last);
            frame_word_t w;
            if (pending_words.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual byte %h last %b",
                         $time, value, last);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (w.data !== value) begin
                $display("%0t ns: frame_byte mismatch, expected %h, actual %h",
                         $time, w.data, value);
                errors++;
            end
            if (w.last !== last) begin
                $display("%0t ns: frame_last mismatch, expected %b, actual %b",
                         $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [16:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic        s_protocol_version;
    logic [15:0] s_command_id;
    logic        s_is_error;
    logic [8:0]  s_payload_length;
    logic [7:0]  s_payload_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_byte;
    logic        m_frame_last;

    reply_frame_tracker book = new();
    bit stalls_on = 1'b1;

    msp_response_framer i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wen            (cfg_wen),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_protocol_version (s_protocol_version),
        .s_command_id       (s_command_id),
        .s_is_error         (s_is_error),
        .s_payload_length   (s_payload_length),
        .s_payload_byte     (s_payload_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_byte       (m_frame_byte),
        .m_frame_last       (m_frame_last)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.match_word(m_frame_byte, m_frame_last);
        end
    end

    function automatic framer_item_t start_item(logic version, logic [15:0] command,
                                                logic is_error, logic [8:0] length);
        framer_item_t it;
        it.opcode = mspfr_pkg::OP_START;
        it.version = version;
        it.command = command;
        it.is_error = is_error;
        it.length = length;
        it.data = 8'($urandom);
        return it;
    endfunction

    function automatic framer_item_t data_item(logic [7:0] value);
        framer_item_t it;
        it.opcode = mspfr_pkg::OP_DATA;
        it.version = 1'($urandom);
        it.command = 16'($urandom);
        it.is_error = 1'($urandom);
        it.length = 9'($urandom);
        it.data = value;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_item(framer_item_t it);
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_opcode = it.opcode;
        s_protocol_version = it.version;
        s_command_id = it.command;
        s_is_error = it.is_error;
        s_payload_length = it.length;
        s_payload_byte = it.data;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.take_item(it);
        @(negedge aclk);
    endtask

    task automatic send_frame(logic version, logic [15:0] command, logic is_error,
                              logic [8:0] length, int count);
        send_item(start_item(version, command, is_error, length));
        repeat (count) send_item(data_item(8'($urandom)));
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (book.pending_words.size() > 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [16:0] value);
        cfg_wen = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wen = 1'b0;
        book.capacity = value;
    endtask

    task automatic random_traffic(int target);
        int sent;
        int kind;
        int len;
        int count;
        logic version;
        logic [15:0] command;
        logic is_error;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            version = 1'($urandom);
            command = 16'($urandom);
            is_error = 1'($urandom);
            if (kind < 80) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8);
                count = len;
                case ($urandom_range(0, 9))
                    0: begin
                        count = $urandom_range(0, len);
                    end
                    1: begin
                        count = len + $urandom_range(1, 2);
                    end
                    default: begin
                    end
                endcase
                send_frame(version, command, is_error, 9'(len), count);
                sent += 1 + count;
            end else if (kind < 90) begin
                send_item(data_item(8'($urandom)));
                sent++;
            end else begin
                count = $urandom_range(0, 3);
                send_frame(version, command, is_error, 9'($urandom_range(0, 511)), count);
                sent += 1 + count;
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_opcode = mspfr_pkg::OP_START;
        s_protocol_version = mspfr_pkg::VERSION_1;
        s_command_id = '0;
        s_is_error = 1'b0;
        s_payload_length = '0;
        s_payload_byte = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_capacity(mspfr_pkg::CAPACITY_RESET);
        send_item(start_item(mspfr_pkg::VERSION_1, 16'hFFFF, 1'b1, 9'd0));
        send_item(start_item(mspfr_pkg::VERSION_2, 16'h0000, 1'b0, 9'd0));
        send_item(start_item(mspfr_pkg::VERSION_2, 16'hABCD, 1'b1, 9'd2));
        send_item(data_item(8'h00));
        send_item(data_item(8'hFF));
        send_item(start_item(mspfr_pkg::VERSION_1, 16'h1234, 1'b0, 9'd3));
        send_item(data_item(8'hFF));
        send_item(data_item(8'h00));
        send_item(data_item(8'hA5));
        send_item(data_item(8'h55));
        send_item(start_item(mspfr_pkg::VERSION_1, 16'h00FF, 1'b1, 9'd4));
        send_item(data_item(8'h5A));
        send_item(start_item(mspfr_pkg::VERSION_2, 16'hFF00, 1'b0, 9'd1));
        send_item(data_item(8'hC3));
        send_item(data_item(8'h3C));
        send_item(start_item(mspfr_pkg::VERSION_2, 16'h8001, 1'b1, 9'd257));
        send_item(data_item(8'h11));
        send_item(start_item(mspfr_pkg::VERSION_1, 16'h7FFE, 1'b0, 9'd511));
        send_item(data_item(8'h22));
        random_traffic(40);
        settle();

        write_capacity(17'd0);
        random_traffic(10);
        settle();

        // A v2 frame of 11 bytes and a v1 frame of 14 bytes just fit in 20.
        write_capacity(17'd20);
        send_frame(mspfr_pkg::VERSION_2, 16'h0102, 1'b0, 9'd11, 11);
        send_frame(mspfr_pkg::VERSION_2, 16'h0304, 1'b1, 9'd12, 2);
        send_frame(mspfr_pkg::VERSION_1, 16'h0506, 1'b0, 9'd14, 14);
        send_frame(mspfr_pkg::VERSION_1, 16'h0708, 1'b1, 9'd15, 2);
        random_traffic(20);
        settle();

        // A v1 start of the largest length fills the capacity exactly; the v2 start does not fit.
        write_capacity(17'd262);
        send_frame(mspfr_pkg::VERSION_1, 16'($urandom), 1'b0, 9'd256, 3);
        send_frame(mspfr_pkg::VERSION_2, 16'($urandom), 1'b1, 9'd256, 1);
        random_traffic(15);
        settle();

        write_capacity(17'd265);
        send_frame(mspfr_pkg::VERSION_2, 16'($urandom), 1'b0, 9'd256, 5);
        send_frame(mspfr_pkg::VERSION_1, 16'($urandom), 1'b1, 9'd2, 2);
        settle();

        write_capacity(17'($urandom_range(6, 300)));
        random_traffic(20);
        settle();

        stalls_on = 1'b0;
        write_capacity(mspfr_pkg::CAPACITY_RESET);
        random_traffic(40);
        settle();

        if (book.errors == 0 && book.pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
